// ----- hdl/scmd_pkg.sv -----
// Package for the stereo chorus: constants, payload types, register codes and the sine table entry function.
package scmd_pkg;

  localparam int DelayDepthDef = 8192;
  localparam int SineDepthDef  = 1024;

  localparam int SampleW   = 24;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;
  localparam int FbMax     = 29491;
  localparam int MixOne    = 32768;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LFO_INC   = 3'd0,
    REG_PHASE_OFS = 3'd1,
    REG_BASE_DLY  = 3'd2,
    REG_MOD_DEPTH = 3'd3,
    REG_FEEDBACK  = 3'd4,
    REG_MIX       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
  } out_item_t;

  // Quarter-wave sine entry k with 2**qbits steps per quadrant, Q1.15, polynomial form.
  function automatic logic [15:0] quarter_entry(input int k, input int qbits);
    longint z, z2, t, s;
    z  = longint'(k) <<< (15 - qbits);
    z2 = (z * z) >>> 15;
    t  = (2611 * z2) >>> 15;
    t  = 21167 - t;
    t  = (t * z2) >>> 15;
    t  = 51472 - t;
    s  = (z * t) >>> 15;
    if (s > 32767) s = 32767;
    return 16'(s);
  endfunction

endpackage

// ----- hdl/scmd_ram.sv -----
// Generic single-port RAM with registered read.
module scmd_ram #(
  parameter int Width = 24,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- hdl/scmd_sine.sv -----
// Quarter-wave sine lookup with registered signed output.
module scmd_sine #(
  parameter int SineDepth = 1024
) (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [16:0] sine
);
  import scmd_pkg::*;

  localparam int TB = $clog2(SineDepth);
  localparam int Q  = SineDepth / 4;
  localparam int WB = TB - 2;
  localparam logic [15:0] MagTop = quarter_entry(Q, WB);

  logic [TB-1:0] idx;
  logic [1:0]    quad;
  logic [WB-1:0] w;
  logic [WB:0]   k;
  logic [15:0]   mag;
  logic [15:0]   rom [Q];

  assign idx  = phase[31 -: TB];
  assign quad = idx[TB-1 -: 2];
  assign w    = idx[WB-1:0];

  // Constant table for the entries below a full quadrant.
  for (genvar j = 0; j < Q; j++) begin : g_rom
    assign rom[j] = quarter_entry(j, WB);
  end

  // Odd quadrants read the table mirrored; the quadrant end is the peak value.
  always_comb begin
    k = quad[0] ? (WB+1)'(Q) - {1'b0, w} : {1'b0, w};
    mag = k[WB] ? MagTop : rom[k[WB-1:0]];
  end

  always_ff @(posedge clk) begin
    sine <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end
endmodule

// ----- hdl/scmd_core.sv -----
// Sequencer that runs both channels through one shared multiply-accumulate unit.
module scmd_core #(
  parameter int DelayDepth = 8192,
  parameter int SineDepth  = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  scmd_pkg::in_item_t   item,
  input  logic [31:0]          lfo_inc,
  input  logic [31:0]          phase_ofs,
  input  logic [20:0]          base_dly,
  input  logic [20:0]          mod_depth,
  input  logic [14:0]          fb_gain,
  input  logic [15:0]          mix_gain,
  output logic                 busy,
  output logic                 done,
  output scmd_pkg::out_item_t  result
);
  import scmd_pkg::*;

  localparam int SampleBits = SampleW;
  localparam int AW   = $clog2(DelayDepth);
  localparam int PosW = AW + 8;
  localparam int AccW = 64;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SINE, S_DLY, S_RD0, S_RD1, S_INT0, S_INT1,
    S_FB, S_MIX0, S_MIX1, S_WR, S_NEXT, S_DONE
  } state_t;

  state_t          state;
  logic            chan;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   wpos;
  logic [31:0]     lfo_phase;
  logic [31:0]     ph;
  logic signed [16:0] sine;
  logic [PosW-1:0] rpos;
  logic signed [SampleBits-1:0] s0, s1, wet, din;
  logic signed [AccW-1:0] acc;
  logic signed [SampleW-1:0] l_res;

  // Shared multiplier operands.
  logic signed [32:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [54:0] prod;

  logic [14:0] fb;
  logic [15:0] mix;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [SampleBits-1:0] ram_wdata;
  logic [SampleBits-1:0] rd_l, rd_r, rdata;
  logic signed [SampleBits-1:0] sat_v;

  assign fb  = (fb_gain > 15'(FbMax)) ? 15'(FbMax) : fb_gain;
  assign mix = (mix_gain > 16'(MixOne)) ? 16'(MixOne) : mix_gain;
  assign ph  = chan ? lfo_phase + phase_ofs : lfo_phase;
  assign din = chan ? SampleBits'(item.right_in) : SampleBits'(item.left_in);
  assign rdata = chan ? rd_r : rd_l;
  assign busy = (state != S_IDLE);

  scmd_sine #(.SineDepth(SineDepth)) u_sine (.clk(clk), .phase(ph), .sine(sine));

  // Saturate the accumulator (after shift) to the sample range.
  function automatic logic signed [SampleBits-1:0] sat(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi, lo;
    hi = (AccW'(1) <<< (SampleBits-1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[SampleBits-1:0];
    if (v < lo) return lo[SampleBits-1:0];
    return v[SampleBits-1:0];
  endfunction

  assign sat_v = sat(acc);

  // Multiplier operand selection by step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DLY:  begin mul_a = 33'(sine); mul_b = $signed({1'b0, mod_depth}); end
      S_INT0: begin mul_a = 33'(s0); mul_b = $signed(22'(9'd256 - {1'b0, rpos[7:0]})); end
      S_INT1: begin mul_a = 33'(s1); mul_b = $signed({14'd0, rpos[7:0]}); end
      S_FB:   begin mul_a = 33'(wet); mul_b = $signed({7'd0, fb}); end
      S_MIX0: begin mul_a = 33'(din); mul_b = $signed(22'(17'(MixOne) - {1'b0, mix})); end
      S_MIX1: begin mul_a = 33'(wet); mul_b = $signed({6'd0, mix}); end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  // Memory control: clear sweep, reads at i0 and i1, write at wpos.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = wpos;
    ram_wdata = sat_v;
    unique case (state)
      S_CLEAR: begin ram_we = 1'b1; ram_addr = clr_addr; ram_wdata = '0; end
      S_RD0:   ram_addr = rpos[PosW-1:8];
      S_RD1:   ram_addr = rpos[PosW-1:8] + AW'(1);
      S_WR:    ram_we = 1'b1;
      default: ;
    endcase
  end

  scmd_ram #(.Width(SampleBits), .Depth(DelayDepth)) u_mem_l (
    .clk(clk), .we(ram_we && (!chan || state == S_CLEAR)), .addr(ram_addr),
    .wdata(ram_wdata), .rdata(rd_l));
  scmd_ram #(.Width(SampleBits), .Depth(DelayDepth)) u_mem_r (
    .clk(clk), .we(ram_we && (chan || state == S_CLEAR)), .addr(ram_addr),
    .wdata(ram_wdata), .rdata(rd_r));

  // Sequencer: at most one multiply per step on the shared multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      wpos <= '0;
      lfo_phase <= '0;
      chan <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DelayDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          chan <= 1'b0;
          if (start) state <= S_SINE;
        end
        S_SINE: state <= S_DLY;
        S_DLY: begin
          rpos <= PosW'({wpos, 8'd0} - PosW'(base_dly) - PosW'(prod >>> 15));
          state <= S_RD0;
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          s0 <= rdata;
          state <= S_INT0;
        end
        S_INT0: begin
          s1 <= rdata;
          acc <= AccW'(prod);
          state <= S_INT1;
        end
        S_INT1: begin
          wet <= SampleBits'((acc + AccW'(prod)) >>> 8);
          state <= S_FB;
        end
        S_FB: begin
          acc <= AccW'(din) + (AccW'(prod) >>> 15);
          state <= S_WR;
        end
        S_WR: begin
          state <= S_MIX0;
        end
        S_MIX0: begin
          acc <= AccW'(prod);
          state <= S_MIX1;
        end
        S_MIX1: begin
          acc <= (acc + AccW'(prod)) >>> 15;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (!chan) begin
            l_res <= SampleW'(sat_v);
            chan <= 1'b1;
            state <= S_SINE;
          end else begin
            result.left_out <= l_res;
            result.right_out <= SampleW'(sat_v);
            lfo_phase <= lfo_phase + lfo_inc;
            wpos <= wpos + AW'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/stereo_chorus_modulated_delay.sv -----
// Top level of the stereo chorus: registers, handshakes and the processing core.
// Once a frame is accepted, its result reaches the output register through these steps:
// eleven sequencer steps per channel around the one shared multiplier and the shared
// memory address, one step to hand over the result and one to load the output register.
// The next frame is accepted once the result has been taken. After reset a clearing pass
// over all DelayDepth addresses (8192 by default) zeroes both delay memories and no frame
// is accepted during it; configuration writes are always taken and belong where no frame
// is in flight.
module stereo_chorus_modulated_delay #(
  parameter int DelayDepth = scmd_pkg::DelayDepthDef,
  parameter int SineDepth  = scmd_pkg::SineDepthDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  scmd_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output scmd_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scmd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [scmd_pkg::CfgDataW-1:0]  cfg_data
);
  import scmd_pkg::*;

  logic [31:0] lfo_inc, phase_ofs;
  logic [20:0] base_dly, mod_depth;
  logic [14:0] fb_gain;
  logic [15:0] mix_gain;
  in_item_t    item;
  logic        busy, done, start;
  out_item_t   result;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy || done || out_valid;
  assign start     = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_inc <= 32'd76056;
      phase_ofs <= 32'd1073741824;
      base_dly <= 21'd147456;
      mod_depth <= 21'd63898;
      fb_gain <= 15'd8192;
      mix_gain <= 16'd16384;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LFO_INC:   lfo_inc <= cfg_data;
        REG_PHASE_OFS: phase_ofs <= cfg_data;
        REG_BASE_DLY:  base_dly <= cfg_data[20:0];
        REG_MOD_DEPTH: mod_depth <= cfg_data[20:0];
        REG_FEEDBACK:  fb_gain <= cfg_data[14:0];
        REG_MIX:       mix_gain <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input capture and output register.
  always_ff @(posedge clk) begin
    if (start) item <= in_data;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
      out_data <= result;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  scmd_core #(.DelayDepth(DelayDepth), .SineDepth(SineDepth))
    u_core (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .lfo_inc(lfo_inc), .phase_ofs(phase_ofs), .base_dly(base_dly),
    .mod_depth(mod_depth), .fb_gain(fb_gain), .mix_gain(mix_gain),
    .busy(busy), .done(done), .result(result));

  // Output valid only after done, done never while full, no request taken while busy.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> !out_valid)
    else $error("result finished while output register full");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("request accepted while busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(done)) else $error("output valid without result");
endmodule
